// ===== src/rcts_pkg.sv =====
// Shared types and constants of the route cost truncation select block.
package rcts_pkg;

  localparam int COST_W = 12;
  localparam int DIST_W = 8;
  localparam int KEEP_W = 7;
  localparam int RANK_W = 6;
  localparam int OUT_IDX_W = 6;
  localparam int CITY_FIELD_W = 4;

  localparam logic [COST_W-1:0] COST_MAX = 12'd4095;
  localparam logic [KEEP_W-1:0] RESULT_MAX = 7'd64;
  localparam logic [KEEP_W-1:0] KEEP_RESET = 7'd32;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_CITY = 2'd1;
  localparam logic [1:0] OP_SELECT = 2'd2;
  localparam logic [1:0] OP_NOP = 2'd3;

  typedef struct packed {
    logic [RANK_W-1:0]    rank;
    logic [OUT_IDX_W-1:0] route_index;
    logic [COST_W-1:0]    route_cost;
    logic                 last;
  } result_t;

  typedef struct packed {
    logic              start;
    logic [KEEP_W-1:0] n;
  } sel_cmd_t;

  typedef struct packed {
    logic res_valid;
    logic done;
  } sel_stat_t;

endpackage

// ===== src/route_cost_truncation_select.sv =====
// Top level of the route cost truncation select block.
//
// Usage: requests enter on the in_ channel (valid/stall). A load request writes
// one entry of the distance table at acceptance. A city request reads the
// table entry from the previous city to this one and adds it to the running
// route cost: the read is issued at acceptance and the sum formed in S_CITY.
// The city that closes a route stores its cost, saturated at 4095, under the
// next arrival index; a route ending with the store full is dropped.
// A select request emits min(keep_count, 64, stored routes) results on the
// out_ channel in ascending cost order, ties to the lower index, then empties
// the store. Each result needs one full scan of the cost store through its
// single read port; in_stall stays high until the last result is loaded.
// Results pass through one output register: a stalled receiver holds that
// register and pauses the scan, nothing is lost. The keep_count register is
// written on the cfg_ channel at any time the block is idle; it is always ready.
// Reset (synchronous, active low) empties the store, restarts the route and
// sets keep_count to 32. The memories are not cleared and need no clearing pass.
module route_cost_truncation_select import rcts_pkg::*; #(
  parameter int MAX_CITIES = 16,
  parameter int MAX_ROUTES = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_opcode,
  input  logic [CITY_FIELD_W-1:0] in_from_city,
  input  logic [CITY_FIELD_W-1:0] in_to_city,
  input  logic [DIST_W-1:0]       in_distance,
  input  logic [CITY_FIELD_W-1:0] in_city,
  input  logic                    in_end_of_route,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [RANK_W-1:0]       out_rank,
  output logic [OUT_IDX_W-1:0]    out_route_index,
  output logic [COST_W-1:0]       out_route_cost,
  output logic                    out_last,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [KEEP_W-1:0]       cfg_keep_count
);

  localparam int CW   = $clog2(MAX_CITIES);
  localparam int TAW  = $clog2(MAX_CITIES * MAX_CITIES);
  localparam int IDXW = $clog2(MAX_ROUTES);
  localparam int CNTW = $clog2(MAX_ROUTES + 1);
  localparam int CMPW = (CNTW > KEEP_W) ? CNTW : KEEP_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CITY = 2'd1;
  localparam logic [1:0] S_SEL  = 2'd2;

  // City numbers are reduced modulo the table size; at most eight subtractions.
  function automatic logic [CW-1:0] city_mod(input logic [CITY_FIELD_W-1:0] v);
    logic [6:0] t;
    t = 7'(v);
    for (int k = 0; k < 8; k++) begin
      if (t >= 7'(MAX_CITIES)) begin
        t = t - 7'(MAX_CITIES);
      end
    end
    return CW'(t);
  endfunction

  logic [1:0]        state_r;
  logic [KEEP_W-1:0] keep_r;
  logic [CNTW-1:0]   route_count_r;
  logic [CW-1:0]     prev_city_r;
  logic              at_start_r;
  logic [COST_W-1:0] run_cost_r;
  logic [CW-1:0]     cur_city_r;
  logic              cur_end_r;

  logic              out_valid_r;
  result_t           out_res_r;

  logic              in_acc;
  logic [CW-1:0]     from_c;
  logic [CW-1:0]     to_c;
  logic [CW-1:0]     route_c;
  logic              tbl_we;
  logic [TAW-1:0]    tbl_waddr;
  logic              tbl_re;
  logic [TAW-1:0]    tbl_raddr;
  logic [DIST_W-1:0] tbl_rdata;

  logic [COST_W:0]   cost_sum;
  logic [COST_W-1:0] cost_nxt;
  logic              store_we;

  logic [KEEP_W-1:0] keep_lim;
  logic [KEEP_W-1:0] sel_n;
  sel_cmd_t          sel_cmd;
  sel_stat_t         sel_stat;
  result_t           sel_res;
  logic              sel_rd_en;
  logic [IDXW-1:0]   sel_rd_addr;
  logic [COST_W-1:0] store_rdata;
  logic              out_load;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign from_c  = city_mod(in_from_city);
  assign to_c    = city_mod(in_to_city);
  assign route_c = city_mod(in_city);

  // Distance table: loads write at acceptance, city requests read at acceptance.
  assign tbl_we    = in_acc && (in_opcode == OP_LOAD);
  assign tbl_waddr = TAW'(from_c * MAX_CITIES + to_c);
  assign tbl_re    = in_acc && (in_opcode == OP_CITY);
  assign tbl_raddr = TAW'(prev_city_r * MAX_CITIES + route_c);

  rcts_ram #(
    .W     (DIST_W),
    .DEPTH (MAX_CITIES * MAX_CITIES),
    .AW    (TAW)
  ) u_dist_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (in_distance),
    .re    (tbl_re),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  // Running cost update in the S_CITY state of a city request; the first city
  // of a route contributes nothing.
  assign cost_sum = {1'b0, run_cost_r} + (COST_W + 1)'(tbl_rdata);
  always_comb begin
    if (at_start_r) begin
      cost_nxt = '0;
    end else if (cost_sum[COST_W]) begin
      cost_nxt = COST_MAX;
    end else begin
      cost_nxt = cost_sum[COST_W-1:0];
    end
  end

  assign store_we = (state_r == S_CITY) && cur_end_r &&
                    (route_count_r < CNTW'(MAX_ROUTES));

  rcts_ram #(
    .W     (COST_W),
    .DEPTH (MAX_ROUTES),
    .AW    (IDXW)
  ) u_cost_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (route_count_r[IDXW-1:0]),
    .wdata (cost_nxt),
    .re    (sel_rd_en),
    .raddr (sel_rd_addr),
    .rdata (store_rdata)
  );

  // Number of results for a select: keep_count, clipped to 64 and to the store.
  assign keep_lim = (keep_r > RESULT_MAX) ? RESULT_MAX : keep_r;
  assign sel_n    = (CMPW'(route_count_r) < CMPW'(keep_lim)) ? KEEP_W'(route_count_r)
                                                            : keep_lim;

  assign sel_cmd.start = in_acc && (in_opcode == OP_SELECT) && (sel_n != '0);
  assign sel_cmd.n     = sel_n;

  // A result moves into the output register whenever that register is free
  // or is being emptied in the same cycle.
  assign out_load = sel_stat.res_valid && (!out_valid_r || !out_stall);

  rcts_selector #(
    .IDXW (IDXW),
    .CNTW (CNTW)
  ) u_selector (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (sel_cmd),
    .count   (route_count_r),
    .take    (out_load),
    .rd_data (store_rdata),
    .rd_en   (sel_rd_en),
    .rd_addr (sel_rd_addr),
    .stat    (sel_stat),
    .res     (sel_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      keep_r        <= KEEP_RESET;
      route_count_r <= '0;
      prev_city_r   <= '0;
      at_start_r    <= 1'b1;
      run_cost_r    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        keep_r <= cfg_keep_count;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc && in_opcode == OP_CITY) begin
            state_r <= S_CITY;
          end else if (in_acc && in_opcode == OP_SELECT) begin
            if (sel_n == '0) begin
              route_count_r <= '0;
            end else begin
              state_r <= S_SEL;
            end
          end
        end
        S_CITY: begin
          prev_city_r <= cur_city_r;
          state_r     <= S_IDLE;
          if (cur_end_r) begin
            at_start_r <= 1'b1;
            run_cost_r <= '0;
            if (store_we) begin
              route_count_r <= route_count_r + 1'b1;
            end
          end else begin
            at_start_r <= 1'b0;
            run_cost_r <= cost_nxt;
          end
        end
        S_SEL: begin
          if (sel_stat.done) begin
            route_count_r <= '0;
            state_r       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_re) begin
      cur_city_r <= route_c;
      cur_end_r  <= in_end_of_route;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res_r <= sel_res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_rank        = out_res_r.rank;
  assign out_route_index = out_res_r.route_index;
  assign out_route_cost  = out_res_r.route_cost;
  assign out_last        = out_res_r.last;

`ifndef SYNTHESIS
  // A city request always returns from S_CITY straight to S_IDLE.
  a_city_two_cycles: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CITY) |=> (state_r == S_IDLE))
    else $error("city request overran its second cycle");

  // The store count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    route_count_r <= CNTW'(MAX_ROUTES))
    else $error("route count beyond capacity");

  // The selector only finishes while a select is in progress, and the store is emptied.
  a_done_in_select: assert property (@(posedge clk) disable iff (!rst_n)
    sel_stat.done |-> (state_r == S_SEL))
    else $error("selection finished outside a select request");

  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    sel_stat.done |=> (route_count_r == '0))
    else $error("route store not emptied after selection");
`endif

endmodule

// ===== src/rcts_ram.sv =====
// Simple dual-port synchronous RAM with one write port and a registered read port.
module rcts_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/rcts_selector.sv =====
// Selection engine: repeated scans of the cost store for the next lowest cost.
module rcts_selector import rcts_pkg::*; #(
  parameter int IDXW = 6,
  parameter int CNTW = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sel_cmd_t          cmd,
  input  logic [CNTW-1:0]   count,
  input  logic              take,
  input  logic [COST_W-1:0] rd_data,
  output logic              rd_en,
  output logic [IDXW-1:0]   rd_addr,
  output sel_stat_t         stat,
  output result_t           res
);

  localparam logic [1:0] SS_IDLE = 2'd0;
  localparam logic [1:0] SS_SCAN = 2'd1;
  localparam logic [1:0] SS_EMIT = 2'd2;

  logic [1:0]        st_r;
  logic [KEEP_W-1:0] n_r;
  logic [KEEP_W-1:0] rank_r;
  logic [CNTW-1:0]   scan_r;
  logic              pv_r;
  logic [IDXW-1:0]   pidx_r;
  logic              found_r;
  logic [COST_W-1:0] best_cost_r;
  logic [IDXW-1:0]   best_idx_r;
  logic              have_last_r;
  logic [COST_W-1:0] last_cost_r;
  logic [IDXW-1:0]   last_idx_r;

  logic              issue;
  logic              elig;
  logic              better;
  logic              final_rank;
  logic [KEEP_W-1:0] rank_inc;

  assign issue   = (st_r == SS_SCAN) && (scan_r < count);
  assign rd_en   = issue;
  assign rd_addr = scan_r[IDXW-1:0];

  // A candidate must come strictly after the previous pick in (cost, index) order.
  assign elig = !have_last_r || (rd_data > last_cost_r) ||
                ((rd_data == last_cost_r) && (pidx_r > last_idx_r));
  // Entries arrive in index order, so a strict compare keeps the lower index on ties.
  assign better = elig && (!found_r || (rd_data < best_cost_r));

  assign rank_inc   = rank_r + 7'd1;
  assign final_rank = (rank_inc == n_r);

  assign stat.res_valid = (st_r == SS_EMIT);
  assign stat.done      = (st_r == SS_EMIT) && take && final_rank;

  assign res.rank        = rank_r[RANK_W-1:0];
  assign res.route_index = OUT_IDX_W'(best_idx_r);
  assign res.route_cost  = best_cost_r;
  assign res.last        = final_rank;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= SS_IDLE;
      pv_r <= 1'b0;
    end else begin
      pv_r <= issue;
      case (st_r)
        SS_IDLE: begin
          if (cmd.start) begin
            st_r <= SS_SCAN;
          end
        end
        SS_SCAN: begin
          if (!issue && !pv_r) begin
            st_r <= SS_EMIT;
          end
        end
        SS_EMIT: begin
          if (take) begin
            st_r <= final_rank ? SS_IDLE : SS_SCAN;
          end
        end
        default: begin
          st_r <= SS_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    pidx_r <= rd_addr;
    if (st_r == SS_IDLE && cmd.start) begin
      n_r         <= cmd.n;
      rank_r      <= '0;
      scan_r      <= '0;
      found_r     <= 1'b0;
      have_last_r <= 1'b0;
    end else if (st_r == SS_SCAN) begin
      if (issue) begin
        scan_r <= scan_r + 1'b1;
      end
      if (pv_r && better) begin
        found_r     <= 1'b1;
        best_cost_r <= rd_data;
        best_idx_r  <= pidx_r;
      end
    end else if (st_r == SS_EMIT && take) begin
      last_cost_r <= best_cost_r;
      last_idx_r  <= best_idx_r;
      have_last_r <= 1'b1;
      rank_r      <= rank_inc;
      scan_r      <= '0;
      found_r     <= 1'b0;
    end
  end

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the route cost truncation select block.
module testbench import rcts_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_CITIES    = 16;
  localparam int MAX_ROUTES    = 64;
  localparam int PREDICTED     = -1;      // directed row without a typed answer
  localparam int PHASES        = 8;
  localparam int FILL_PHASE    = 3;       // the phase that overfills the cost store
  localparam int PHASE_ITEMS   = 22;
  localparam int FILL_ROUTES   = 70;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 32;
  localparam int TAIL_CYCLES   = 40;
  localparam int CYCLE_LIMIT   = 20000000;

  // One request on the input channel, field for field.
  typedef struct packed {
    logic [1:0]              opcode;
    logic [CITY_FIELD_W-1:0] from_city;
    logic [CITY_FIELD_W-1:0] to_city;
    logic [DIST_W-1:0]       distance;
    logic [CITY_FIELD_W-1:0] city;
    logic                    end_of_route;
  } request_t;

  // A directed request and, where it can be read off directly, its answer.
  typedef struct packed {
    request_t req;
    int       fixed_count;
    result_t  fixed_result;
  } directed_row_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [1:0]              in_opcode;
  logic [CITY_FIELD_W-1:0] in_from_city;
  logic [CITY_FIELD_W-1:0] in_to_city;
  logic [DIST_W-1:0]       in_distance;
  logic [CITY_FIELD_W-1:0] in_city;
  logic                    in_end_of_route;
  logic                    out_valid;
  logic                    out_stall;
  logic [RANK_W-1:0]       out_rank;
  logic [OUT_IDX_W-1:0]    out_route_index;
  logic [COST_W-1:0]       out_route_cost;
  logic                    out_last;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [KEEP_W-1:0]       cfg_keep_count;

  route_cost_truncation_select uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_from_city    (in_from_city),
    .in_to_city      (in_to_city),
    .in_distance     (in_distance),
    .in_city         (in_city),
    .in_end_of_route (in_end_of_route),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_rank        (out_rank),
    .out_route_index (out_route_index),
    .out_route_cost  (out_route_cost),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_keep_count  (cfg_keep_count)
  );

  // Our own copy of the block's state. It is advanced at the clock edge on
  // which a request is accepted, so the stimulus generator can also consult
  // it (for instance to know which table entries are safe to read).
  logic [DIST_W-1:0] dist_tab [MAX_CITIES][MAX_CITIES];
  bit                tab_written [MAX_CITIES][MAX_CITIES];
  logic [COST_W-1:0] cost_store [MAX_ROUTES];
  int                route_cnt = 0;
  logic [3:0]        pred_prev = '0;
  bit                pred_at_start = 1'b1;
  int                run_cost = 0;
  logic [KEEP_W-1:0] keep_now = KEEP_RESET;

  result_t       new_picks[$];       // selections caused by the latest request
  result_t       expected_picks[$];  // selections still awaited on the output
  directed_row_t directed_rows[$];

  int mismatches = 0;
  int items_sent = 0;
  int burst_left = 0;
  int cycle_count = 0;
  bit hold_request = 1'b0;
  bit hold_done = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one accepted request to the predicted state and collect the
  // selections that it produces in new_picks.
  task automatic predict_picks(input request_t r);
    int n;
    int k;
    int i;
    int best;
    int sum;
    bit found;
    logic [COST_W-1:0] best_cost;
    logic [MAX_ROUTES-1:0] taken;
    result_t pick;
    new_picks.delete();
    case (r.opcode)
      OP_LOAD: begin
        dist_tab[r.from_city][r.to_city] = r.distance;
        tab_written[r.from_city][r.to_city] = 1'b1;
      end
      OP_CITY: begin
        // The first city of a route costs nothing; each later one adds the
        // hop from the previous city, saturating at the top of the range.
        if (pred_at_start) begin
          run_cost = 0;
          pred_at_start = 1'b0;
        end else begin
          sum = run_cost + int'(dist_tab[pred_prev][r.city]);
          run_cost = (sum > int'(COST_MAX)) ? int'(COST_MAX) : sum;
        end
        pred_prev = r.city;
        if (r.end_of_route) begin
          // A route that ends with the store full is simply lost.
          if (route_cnt < MAX_ROUTES) begin
            cost_store[route_cnt] = COST_W'(run_cost);
            route_cnt++;
          end
          pred_at_start = 1'b1;
          run_cost = 0;
        end
      end
      OP_SELECT: begin
        n = int'(keep_now);
        if (n > int'(RESULT_MAX))
          n = int'(RESULT_MAX);
        if (n > route_cnt)
          n = route_cnt;
        taken = '0;
        for (k = 0; k < n; k++) begin
          found = 1'b0;
          best = 0;
          best_cost = '0;
          // Strictly lower cost wins, so ties stay with the earlier route.
          for (i = 0; i < route_cnt; i++) begin
            if (!taken[i] && (!found || cost_store[i] < best_cost)) begin
              found = 1'b1;
              best = i;
              best_cost = cost_store[i];
            end
          end
          taken[best] = 1'b1;
          pick.rank = RANK_W'(k);
          pick.route_index = OUT_IDX_W'(best);
          pick.route_cost = best_cost;
          pick.last = (k + 1 == n);
          new_picks.insert(new_picks.size(), pick);
        end
        // The store is emptied even when nothing was emitted; a route that
        // is half streamed carries on untouched.
        route_cnt = 0;
      end
      default: ;
    endcase
  endtask

  // Sender pacing: mostly back to back or short gaps, the odd long pause,
  // and now and then a burst of requests with no gap at all.
  function automatic int idle_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 8) begin
      burst_left = $urandom_range(20, 40);
      return 0;
    end
    if (r < 50)
      return 0;
    if (r < 85)
      return $urandom_range(1, 3);
    if (r < 97)
      return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  // Present one request, hold it until the block takes it, then predict.
  // Valid is only lowered when a gap actually follows, so a request that
  // follows straight on never sees valid dropped and raised in one step.
  task automatic send_request(input request_t r, input int fixed_count,
                              input result_t fixed_result);
    int gap;
    gap = idle_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_opcode       <= r.opcode;
    in_from_city    <= r.from_city;
    in_to_city      <= r.to_city;
    in_distance     <= r.distance;
    in_city         <= r.city;
    in_end_of_route <= r.end_of_route;
    do @(posedge clk); while (in_stall);
    predict_picks(r);
    if (r.opcode != OP_NOP)
      items_sent++;
    if (fixed_count == PREDICTED) begin
      foreach (new_picks[i])
        expected_picks.insert(expected_picks.size(), new_picks[i]);
    end else if (fixed_count > 0) begin
      expected_picks.insert(expected_picks.size(), fixed_result);
    end
  endtask

  task automatic send(input request_t r);
    send_request(r, PREDICTED, '0);
  endtask

  // A request of the given kind whose unused fields carry random bits.
  function automatic request_t shaped(input logic [1:0] op);
    logic [31:0] bits;
    request_t r;
    bits = $urandom;
    r = bits[$bits(request_t)-1:0];
    r.opcode = op;
    return r;
  endfunction

  function automatic request_t load_req(input logic [3:0] f, input logic [3:0] t,
                                        input logic [DIST_W-1:0] d);
    request_t r;
    r = shaped(OP_LOAD);
    r.from_city = f;
    r.to_city = t;
    r.distance = d;
    return r;
  endfunction

  function automatic request_t city_req(input logic [3:0] c, input logic eor);
    request_t r;
    r = shaped(OP_CITY);
    r.city = c;
    r.end_of_route = eor;
    return r;
  endfunction

  // Distances lean towards both ends of the range.
  function automatic logic [DIST_W-1:0] pick_distance();
    int r;
    r = $urandom_range(0, 3);
    if (r == 0)
      return '0;
    if (r == 1)
      return '1;
    return DIST_W'($urandom_range(0, 255));
  endfunction

  // Background traffic that never disturbs a route: a stray table load or
  // a no-operation request.
  function automatic request_t noise_req();
    if ($urandom_range(0, 1) == 1)
      return load_req(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                      pick_distance());
    return shaped(OP_NOP);
  endfunction

  // Stream the cities of a route. Before any hop whose table entry has never
  // been loaded, that entry is loaded first, so an unwritten distance never
  // enters a cost. A heavy route loops on city 15 with the largest distance
  // until the cost saturates. With noise on, stray loads, no-operation
  // requests and selects land in the middle of the route.
  task automatic stream_route(input int len, input bit heavy, input bit noisy);
    logic [3:0] c;
    int k;
    if (heavy)
      send(load_req(4'hF, 4'hF, 8'hFF));
    for (k = 0; k < len; k++) begin
      c = heavy ? 4'hF : 4'($urandom_range(0, 15));
      if (!pred_at_start && !tab_written[pred_prev][c])
        send(load_req(pred_prev, c, pick_distance()));
      if (noisy && $urandom_range(0, 11) == 0)
        send(($urandom_range(0, 2) == 0) ? shaped(OP_SELECT) : noise_req());
      send(city_req(c, k == len - 1));
    end
  endtask

  // Wait until every awaited selection has come out, then a little longer.
  task automatic settle_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_picks.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_keep(input logic [KEEP_W-1:0] value);
    @(negedge clk);
    cfg_valid      <= 1'b1;
    cfg_keep_count <= value;
    do @(posedge clk); while (!cfg_ready);
    keep_now = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_row(input logic [1:0] op, input logic [3:0] f, input logic [3:0] t,
                         input logic [DIST_W-1:0] d, input logic [3:0] c,
                         input logic eor, input int n, input result_t res);
    directed_row_t row;
    row.req = {op, f, t, d, c, eor};
    row.fixed_count = n;
    row.fixed_result = res;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // A mixed phase: routes of random length with noise, a saturating route
  // where allowed, selects and stray requests, closed by a select.
  task automatic mixed_traffic(input int budget, input bit allow_heavy);
    int start;
    int r;
    bit heavy_done;
    start = items_sent;
    heavy_done = 1'b0;
    while (items_sent - start < budget) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        stream_route($urandom_range(1, 6), 1'b0, 1'b1);
      end else if (r < 62 && allow_heavy && !heavy_done) begin
        stream_route($urandom_range(18, 21), 1'b1, 1'b0);
        heavy_done = 1'b1;
      end else if (r < 80) begin
        send(shaped(OP_SELECT));
      end else begin
        send(noise_req());
      end
    end
    send(shaped(OP_SELECT));
  endtask

  // Overfill the cost store with single-city routes so that the last few are
  // dropped, then select them all. The receiver is asked to hold off when the
  // first of those selections appears, while more route requests queue up
  // behind the select and the block has to stall its input.
  task automatic fill_store();
    int k;
    for (k = 0; k < FILL_ROUTES; k++) begin
      if (k % 10 == 5)
        send(noise_req());
      stream_route(1, 1'b0, 1'b0);
    end
    hold_request = 1'b1;
    send(shaped(OP_SELECT));
    for (k = 0; k < 6; k++)
      stream_route($urandom_range(1, 3), 1'b0, 1'b0);
    send(shaped(OP_SELECT));
  endtask

  // Receiver pacing: alternating spells of stalling and accepting. Most
  // stalls are short, a few are long, and some accepting spells are long
  // enough to count as stretches without any stall. The single long hold-off
  // is counted here, in the receiver's own process.
  initial begin : sink_pacing
    int span;
    int r;
    bit level;
    out_stall = 1'b0;
    level = 1'b0;
    span = 0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done && out_valid) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        hold_done = 1'b1;
        level = 1'b0;
        span = $urandom_range(1, 4);
        out_stall <= 1'b0;
      end else begin
        if (span == 0) begin
          level = ~level;
          r = $urandom_range(0, 99);
          if (level)
            span = (r < 70) ? $urandom_range(1, 3) :
                   (r < 95) ? $urandom_range(4, 12) : $urandom_range(30, 80);
          else
            span = (r < 15) ? $urandom_range(40, 150) : $urandom_range(1, 8);
        end
        span--;
        out_stall <= level;
      end
    end
  end

  task automatic check_field(input string what, input logic [COST_W-1:0] want,
                             input logic [COST_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  // Every selection taken by the receiver is compared with the oldest one
  // still awaited.
  always @(posedge clk) begin : selection_check
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_picks.size() == 0) begin
        mismatches++;
        $display("%0t: selection with none awaited: rank %0d index %0d cost %0d last %0d",
                 $time, out_rank, out_route_index, out_route_cost, out_last);
      end else begin
        want = expected_picks.pop_front();
        check_field("rank", COST_W'(want.rank), COST_W'(out_rank));
        check_field("route_index", COST_W'(want.route_index), COST_W'(out_route_index));
        check_field("route_cost", want.route_cost, out_route_cost);
        check_field("last", COST_W'(want.last), COST_W'(out_last));
      end
    end
  end

  // Watchdog: a run that hangs is a failure.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int phase;
    logic [KEEP_W-1:0] keep;

    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_opcode       = OP_NOP;
    in_from_city    = '0;
    in_to_city      = '0;
    in_distance     = '0;
    in_city         = '0;
    in_end_of_route = 1'b0;
    cfg_valid       = 1'b0;
    cfg_keep_count  = '0;

    // Directed requests, run with keep_count at its reset value of 32.
    // An empty select gives nothing; a lone single-city route costs zero.
    add_row(OP_SELECT, 4'h0, 4'h0, 8'h00, 4'h0, 1'b0, 0, '0);
    add_row(OP_CITY,   4'h0, 4'h0, 8'h00, 4'hF, 1'b1, PREDICTED, '0);
    add_row(OP_SELECT, 4'h0, 4'h0, 8'h00, 4'h0, 1'b0, 1, {6'd0, 6'd0, 12'd0, 1'b1});
    // Table corners, including the largest distance.
    add_row(OP_LOAD,   4'hF, 4'hF, 8'hFF, 4'h0, 1'b0, PREDICTED, '0);
    add_row(OP_LOAD,   4'h0, 4'h0, 8'h00, 4'h0, 1'b0, PREDICTED, '0);
    add_row(OP_LOAD,   4'h0, 4'hF, 8'h01, 4'h0, 1'b0, PREDICTED, '0);
    add_row(OP_LOAD,   4'hF, 4'h0, 8'h80, 4'h0, 1'b0, PREDICTED, '0);
    // Route 0 -> 15 -> 15 -> 0 costs 1 + 255 + 128.
    add_row(OP_CITY,   4'h0, 4'h0, 8'h00, 4'h0, 1'b0, PREDICTED, '0);
    add_row(OP_CITY,   4'h0, 4'h0, 8'h00, 4'hF, 1'b0, PREDICTED, '0);
    add_row(OP_CITY,   4'h0, 4'h0, 8'h00, 4'hF, 1'b0, PREDICTED, '0);
    add_row(OP_CITY,   4'h0, 4'h0, 8'h00, 4'h0, 1'b1, PREDICTED, '0);
    // Two zero-cost routes either side of a 255 one, to force a tie.
    add_row(OP_CITY,   4'h0, 4'h0, 8'h00, 4'h9, 1'b1, PREDICTED, '0);
    add_row(OP_CITY,   4'h0, 4'h0, 8'h00, 4'hF, 1'b0, PREDICTED, '0);
    add_row(OP_CITY,   4'h0, 4'h0, 8'h00, 4'hF, 1'b1, PREDICTED, '0);
    add_row(OP_CITY,   4'h0, 4'h0, 8'h00, 4'h6, 1'b1, PREDICTED, '0);
    // A route is left open across the select and a no-operation request.
    add_row(OP_CITY,   4'h0, 4'h0, 8'h00, 4'h0, 1'b0, PREDICTED, '0);
    add_row(OP_SELECT, 4'h0, 4'h0, 8'h00, 4'h0, 1'b0, PREDICTED, '0);
    add_row(OP_NOP,    4'hF, 4'hF, 8'hFF, 4'hF, 1'b1, PREDICTED, '0);
    add_row(OP_CITY,   4'h0, 4'h0, 8'h00, 4'h0, 1'b1, PREDICTED, '0);
    add_row(OP_SELECT, 4'h0, 4'h0, 8'h00, 4'h0, 1'b0, 1, {6'd0, 6'd0, 12'd0, 1'b1});
    // Reloading an entry takes effect on the next route.
    add_row(OP_LOAD,   4'h0, 4'h0, 8'hFF, 4'h0, 1'b0, PREDICTED, '0);
    add_row(OP_CITY,   4'h0, 4'h0, 8'h00, 4'h0, 1'b0, PREDICTED, '0);
    add_row(OP_CITY,   4'h0, 4'h0, 8'h00, 4'h0, 1'b1, PREDICTED, '0);
    add_row(OP_SELECT, 4'h0, 4'h0, 8'h00, 4'h0, 1'b0, 1, {6'd0, 6'd0, 12'd255, 1'b1});

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].fixed_count,
                   directed_rows[i].fixed_result);

    // Random phases, each under its own keep_count. The setting is changed
    // only once the block has gone quiet, and covers one, zero, exactly the
    // output limit, all ones (above the limit) and a few ordinary values.
    for (phase = 0; phase < PHASES; phase++) begin
      settle_block();
      case (phase)
        0:       keep = 7'd1;
        1:       keep = 7'd0;
        2:       keep = 7'd64;
        3:       keep = 7'd127;
        4:       keep = 7'd5;
        5:       keep = 7'd2;
        default: keep = KEEP_W'($urandom_range(0, 127));
      endcase
      write_keep(keep);
      if (phase == FILL_PHASE)
        fill_store();
      else
        mixed_traffic(PHASE_ITEMS, phase == 2 || phase == 4 || phase == 6);
    end

    settle_block();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/rcts_pkg.sv
src/rcts_ram.sv
src/rcts_selector.sv
src/route_cost_truncation_select.sv
test/testbench.sv
